### rtl/great_circle_initial_bearing_core_defines.svh
// Assertion macros used by the RTL file that carries checks.
// Each macro expects clk and rst_n in scope.
`ifndef GREAT_CIRCLE_INITIAL_BEARING_CORE_DEFINES_SVH
`define GREAT_CIRCLE_INITIAL_BEARING_CORE_DEFINES_SVH

// Same-cycle implication.
`define GCIB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GCIB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gcib_pkg.sv
package gcib_pkg;

  localparam int ANGLE_W     = 32;
  // Angle accumulator: 32-bit binary angle plus headroom for the table sum.
  localparam int ZW          = 34;
  localparam int TABLE_LEN   = 32;
  localparam int TABLE_IDX_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROT,
    ST_STORE,
    ST_VSETUP,
    ST_VEC,
    ST_FINISH
  } state_t;

  // Rotation passes of the product chain, in order.
  typedef enum logic [2:0] {
    PH_LAT2,
    PH_SIN_LAT2,
    PH_DLON,
    PH_X,
    PH_LAT1
  } phase_t;

  // atan(2^-i) in 2^-32 turn units.
  function automatic logic [ANGLE_W-1:0] atan_entry(input logic [TABLE_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051D;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2E;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2F9;
      5'd15:   val = 32'h0000517C;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A2F;
      5'd19:   val = 32'h00000517;
      5'd20:   val = 32'h0000028B;
      5'd21:   val = 32'h00000145;
      5'd22:   val = 32'h000000A2;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000028;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000002;
      5'd29:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

### rtl/great_circle_initial_bearing_core.sv
// Channel   Dir  Handshake            Payload
// in_*      in   in_tvalid/in_tready   in_tdata: from_lat, from_lon, to_lat, to_lon
// out_*     out  out_tvalid/out_tready out_tdata: bearing_angle
//
// One CORDIC micro-rotation unit (two shifters, three adders) runs five rotation
// passes and one vectoring pass, each of N = min(CORDIC_ITERATIONS, 32) steps.
// The result is registered in the output register; an input is accepted only in
// the idle state, so the core works on one item at a time.
// rst_n is synchronous, active low; it clears the sequencer and the output valid.
// A stalled result holds in the output register; the next input is taken meanwhile.
`include "great_circle_initial_bearing_core_defines.svh"

module great_circle_initial_bearing_core #(
  parameter int CORDIC_ITERATIONS = 24,
  parameter int INTERNAL_BITS     = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] from_latitude, [63:32] from_longitude, [95:64] to_latitude,
  // [127:96] to_longitude
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] bearing_angle
  output logic [15:0]  out_tdata
);

  import gcib_pkg::*;

  // Headroom for the K^4 gain of the chain plus CORDIC overshoot.
  localparam int VW    = INTERNAL_BITS + 3;
  localparam int NITER = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
  localparam logic [TABLE_IDX_W-1:0] LAST_CNT = TABLE_IDX_W'(NITER - 1);
  localparam logic signed [VW-1:0] START_MAG =
    {{(VW-1){1'b0}}, 1'b1} << (INTERNAL_BITS - 4);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [TABLE_IDX_W-1:0] cnt_r, cnt_nxt;

  logic signed [VW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [VW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [ANGLE_W-1:0]   lat1n_r, lat1n_nxt, lat2_r, lat2_nxt, dlon_r, dlon_nxt;
  logic                 base_r, base_nxt, zero_r, zero_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [15:0]          out_data_r, out_data_nxt;

  logic                 in_xfer, last_step, out_free;
  logic signed [VW-1:0] sx, sy, dx, dy;
  logic [ANGLE_W-1:0]   sang, ang_f, ang_out, ang_rnd;
  logic                 fold, sigma, y_pos;
  logic signed [ZW-1:0] atan_z;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign last_step  = (cnt_r == LAST_CNT);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = ST_ROT;
      ST_ROT:    if (last_step) state_nxt = ST_STORE;
      ST_STORE:  state_nxt = (phase_r == PH_LAT1) ? ST_VSETUP : ST_SETUP;
      ST_VSETUP: state_nxt = ST_VEC;
      ST_VEC:    if (last_step) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Shared micro-rotation unit
  always_comb begin
    dx     = y_r >>> cnt_r;
    dy     = x_r >>> cnt_r;
    atan_z = {{(ZW-ANGLE_W){1'b0}}, atan_entry(cnt_r)};
    y_pos  = !y_r[VW-1] && (y_r != '0);
    sigma  = (state_r == ST_VEC) ? !y_pos : !z_r[ZW-1];
  end

  // Operand selection for the rotation passes
  always_comb begin
    sx   = START_MAG;
    sy   = '0;
    sang = lat2_r;
    case (phase_r)
      PH_LAT2: begin
        sx   = START_MAG;
        sang = lat2_r;
      end
      PH_SIN_LAT2: begin
        sx   = b_r;
        sang = '0;
      end
      PH_DLON: begin
        sx   = a_r;
        sang = dlon_r;
      end
      PH_X: begin
        sx   = c_r;
        sang = '0;
      end
      PH_LAT1: begin
        sx   = a_r;
        sy   = b_r;
        sang = lat1n_r;
      end
      default: begin
        sx   = START_MAG;
        sang = lat2_r;
      end
    endcase
    // Fold second and third quadrant angles by a half turn.
    fold  = sang[ANGLE_W-1] ^ sang[ANGLE_W-2];
    ang_f = {sang[ANGLE_W-1] ^ fold, sang[ANGLE_W-2:0]};
  end

  assign ang_out = zero_r ? '0 : ({base_r, {(ANGLE_W-1){1'b0}}} + z_r[ANGLE_W-1:0]);
  assign ang_rnd = ang_out + ANGLE_W'(32'h8000);

  // Datapath and handshake outputs
  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    lat1n_nxt     = lat1n_r;
    lat2_nxt      = lat2_r;
    dlon_nxt      = dlon_r;
    base_nxt      = base_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          lat1n_nxt = ANGLE_W'(0) - in_tdata[31:0];
          lat2_nxt  = in_tdata[95:64];
          dlon_nxt  = in_tdata[127:96] - in_tdata[63:32];
          phase_nxt = PH_LAT2;
        end
      end
      ST_SETUP: begin
        x_nxt   = fold ? -sx : sx;
        y_nxt   = fold ? -sy : sy;
        z_nxt   = {{(ZW-ANGLE_W){ang_f[ANGLE_W-1]}}, ang_f};
        cnt_nxt = '0;
      end
      ST_ROT, ST_VEC: begin
        if (sigma) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_z;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_z;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_STORE: begin
        case (phase_r)
          PH_LAT2: begin
            a_nxt = x_r;
            b_nxt = y_r;
          end
          PH_SIN_LAT2: b_nxt = x_r;
          PH_DLON: begin
            a_nxt = x_r;
            c_nxt = y_r;
          end
          PH_X:    c_nxt = x_r;
          PH_LAT1: a_nxt = y_r;
          default: a_nxt = a_r;
        endcase
        phase_nxt = phase_t'(phase_r + 3'd1);
      end
      ST_VSETUP: begin
        // Vector (X, Y) lives in a_r / c_r; mirror it into the right half plane.
        zero_nxt = (a_r == '0) && (c_r == '0);
        base_nxt = a_r[VW-1];
        x_nxt    = a_r[VW-1] ? -a_r : a_r;
        y_nxt    = a_r[VW-1] ? -c_r : c_r;
        z_nxt    = '0;
        cnt_nxt  = '0;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ang_rnd[ANGLE_W-1:ANGLE_W-16];
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_LAT2;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    lat1n_r    <= lat1n_nxt;
    lat2_r     <= lat2_nxt;
    dlon_r     <= dlon_nxt;
    base_r     <= base_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  `GCIB_ASSERT_NEXT(a_start_chain, in_xfer, (state_r == ST_SETUP) && (phase_r == PH_LAT2), "input transfer did not start the rotation chain")
  `GCIB_ASSERT_SAME(a_cnt_range, (state_r == ST_ROT) || (state_r == ST_VEC), cnt_r <= LAST_CNT, "iteration counter ran past the last step")
  `GCIB_ASSERT_SAME(a_phase_range, state_r == ST_SETUP, phase_r <= PH_LAT1, "setup reached with no rotation pass left")
  `GCIB_ASSERT_SAME(a_result_src, $rose(out_valid_r), $past(state_r) == ST_FINISH, "result appeared outside the finish step")

endmodule
